// ===== hw/rtl/fpla_pkg.sv =====
// Shared constants, codes and types of the free page list allocator.
// No dependencies; every other file of the block takes names from here.
package fpla_pkg;

    // Geometry of the page pool
    localparam int NUM_PAGES   = 1024;
    localparam int PAGE_W      = $clog2(NUM_PAGES);
    localparam int LINK_W      = PAGE_W + 1;
    localparam int CNT_W       = PAGE_W + 1;
    localparam int SUM_W       = PAGE_W + 2;
    localparam int PAGE_SIZE_W = 21;
    localparam int STAT_W      = 32;
    localparam int CMD_W       = 2;
    localparam int STATUS_W    = 2;

    localparam logic [LINK_W-1:0]      HEAD_EMPTY      = LINK_W'(NUM_PAGES);
    localparam logic [CNT_W-1:0]       CNT_FULL        = CNT_W'(NUM_PAGES);
    localparam logic [SUM_W-1:0]       SUM_FULL        = SUM_W'(NUM_PAGES);
    localparam logic [PAGE_SIZE_W-1:0] PAGE_SIZE_RESET = PAGE_SIZE_W'(4096);

    // Command codes
    localparam logic [CMD_W-1:0] CMD_ALLOC = 2'd0;
    localparam logic [CMD_W-1:0] CMD_FREE  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_ADD   = 2'd2;
    localparam logic [CMD_W-1:0] CMD_STATS = 2'd3;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_REFUSED = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BOUNDS  = 2'd2;

    // Request from the controller to the link memory
    typedef struct packed {
        logic              wr_en;
        logic [PAGE_W-1:0] wr_addr;
        logic [LINK_W-1:0] wr_data;
        logic              rd_en;
        logic [PAGE_W-1:0] rd_addr;
    } ram_req_t;

    // One result item as produced by the controller
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [PAGE_W-1:0]   granted_page;
        logic [CNT_W-1:0]    free_pages;
        logic [STAT_W-1:0]   alloc_count;
        logic [STAT_W-1:0]   free_count;
    } result_t;

endpackage

// ===== hw/rtl/free_page_list_allocator_unit.sv =====
// Top level of the free page list allocator: config register, result register.
// Depends on fpla_pkg, fpla_ctrl and fpla_link_ram.
//
//   channel   direction   handshake              payload
//   in        input       in_valid / in_stall    command, byte_count, page_index, page_count
//   out       output      out_valid / out_stall  status, granted_page, free_pages,
//                                                alloc_count, free_count
//   cfg       input       cfg_valid / cfg_ready  cfg_data (page_size_bytes)
//
// Free, statistics, refused allocate and an empty or out-of-range add-block finish in idle;
// a granted allocate also needs the pop state for the registered read of the head's link.
// An in-range add-block runs the fill state, one link write per page on the single write port.
// Reset clears head (empty), counters and page size (4096); link memory is not cleared.
// A new item is taken while the last result waits, unless out_stall holds it or the controller is busy.
module free_page_list_allocator_unit (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [fpla_pkg::CMD_W-1:0]           command,
    input  logic [fpla_pkg::PAGE_SIZE_W-1:0]     byte_count,
    input  logic [fpla_pkg::PAGE_W-1:0]          page_index,
    input  logic [fpla_pkg::CNT_W-1:0]           page_count,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [fpla_pkg::STATUS_W-1:0]        status,
    output logic [fpla_pkg::PAGE_W-1:0]          granted_page,
    output logic [fpla_pkg::CNT_W-1:0]           free_pages,
    output logic [fpla_pkg::STAT_W-1:0]          alloc_count,
    output logic [fpla_pkg::STAT_W-1:0]          free_count,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [fpla_pkg::PAGE_SIZE_W-1:0]     cfg_data
);

    logic [fpla_pkg::PAGE_SIZE_W-1:0] page_size_reg;
    logic                             out_valid_reg;
    fpla_pkg::result_t                out_reg;
    logic                             out_room;
    logic                             res_load;
    fpla_pkg::result_t                res;
    fpla_pkg::ram_req_t               ram_req;
    logic [fpla_pkg::LINK_W-1:0]      ram_rdata;

    // Store the page size
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            page_size_reg <= fpla_pkg::PAGE_SIZE_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            page_size_reg <= cfg_data;
        end
    end

    fpla_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .command    (command),
        .byte_count (byte_count),
        .page_index (page_index),
        .page_count (page_count),
        .page_size  (page_size_reg),
        .out_room   (out_room),
        .res_load   (res_load),
        .res        (res),
        .ram_req    (ram_req),
        .ram_rdata  (ram_rdata)
    );

    fpla_link_ram u_link_ram (
        .clk   (clk),
        .req   (ram_req),
        .rdata (ram_rdata)
    );

    // Result register: load a new item when empty or being taken
    assign out_room = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_room)
        begin
            out_valid_reg <= res_load;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            out_reg <= res;
        end
    end

    assign out_valid    = out_valid_reg;
    assign status       = out_reg.status;
    assign granted_page = out_reg.granted_page;
    assign free_pages   = out_reg.free_pages;
    assign alloc_count  = out_reg.alloc_count;
    assign free_count   = out_reg.free_count;

    // No item is taken while a result is held back
    a_no_accept_over_held: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |-> !(out_valid_reg && out_stall))
        else $error("item accepted while result register is stalled");

    // A granted allocate blocks the next item for the link read
    a_pop_interlock: assert property (@(posedge clk) disable iff (!rst_n)
        (res_load && (command == fpla_pkg::CMD_ALLOC) && (res.status == fpla_pkg::ST_OK))
        |=> in_stall)
        else $error("item accepted during head pop");

    // Free page count never exceeds the pool
    a_free_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (free_pages <= fpla_pkg::CNT_FULL))
        else $error("free page count above pool size");

    // A refused or bounds status never grants a page
    a_no_grant_on_error: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (status != fpla_pkg::ST_OK)) |-> (granted_page == '0))
        else $error("page granted with error status");

endmodule

// ===== hw/rtl/fpla_link_ram.sv =====
// Next-pointer memory of the free list: one write port, one registered read port.
// Depends on fpla_pkg for depth, widths and the request struct.
module fpla_link_ram (
    input  logic                               clk,
    input  fpla_pkg::ram_req_t                 req,
    output logic [fpla_pkg::LINK_W-1:0]        rdata
);

    logic [fpla_pkg::LINK_W-1:0] mem [fpla_pkg::NUM_PAGES];

    // Write a link
    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
    end

    // Read a link, data in the next cycle
    always_ff @(posedge clk)
    begin
        if (req.rd_en)
        begin
            rdata <= mem[req.rd_addr];
        end
    end

endmodule

// ===== hw/rtl/fpla_ctrl.sv =====
// Command sequencer of the allocator: head, counters, pop and block fill.
// Depends on fpla_pkg; drives the link memory through a ram_req_t.
module fpla_ctrl (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [fpla_pkg::CMD_W-1:0]           command,
    input  logic [fpla_pkg::PAGE_SIZE_W-1:0]     byte_count,
    input  logic [fpla_pkg::PAGE_W-1:0]          page_index,
    input  logic [fpla_pkg::CNT_W-1:0]           page_count,
    input  logic [fpla_pkg::PAGE_SIZE_W-1:0]     page_size,
    input  logic                                 out_room,
    output logic                                 res_load,
    output fpla_pkg::result_t                    res,
    output fpla_pkg::ram_req_t                   ram_req,
    input  logic [fpla_pkg::LINK_W-1:0]          ram_rdata
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_POP  = 2'd1;
    localparam logic [1:0] S_FILL = 2'd2;

    logic [1:0]                      state_reg, state_next;
    logic [fpla_pkg::LINK_W-1:0]     head_reg, head_next;
    logic [fpla_pkg::CNT_W-1:0]      pf_reg, pf_next;
    logic [fpla_pkg::STAT_W-1:0]     alloc_cnt_reg, alloc_cnt_next;
    logic [fpla_pkg::STAT_W-1:0]     free_cnt_reg, free_cnt_next;
    logic [fpla_pkg::PAGE_W-1:0]     cursor_reg, cursor_next;
    logic [fpla_pkg::CNT_W-1:0]      remain_reg, remain_next;
    logic [fpla_pkg::LINK_W-1:0]     tail_reg, tail_next;

    logic                            accept;
    logic                            alloc_ok;
    logic [fpla_pkg::SUM_W-1:0]      blk_end;
    logic                            blk_oob;
    logic [fpla_pkg::SUM_W-1:0]      room;
    logic [fpla_pkg::CNT_W-1:0]      pf_add_one;
    logic [fpla_pkg::CNT_W-1:0]      pf_add_blk;

    // Add pages to the free count, saturating at the pool size
    function automatic logic [fpla_pkg::CNT_W-1:0] add_sat(
        input logic [fpla_pkg::CNT_W-1:0] pf,
        input logic [fpla_pkg::CNT_W-1:0] n,
        input logic [fpla_pkg::SUM_W-1:0] left
    );
        logic [fpla_pkg::SUM_W-1:0] sum;
        sum = {1'b0, pf} + {1'b0, n};
        if ({1'b0, n} >= left)
        begin
            return fpla_pkg::CNT_FULL;
        end
        return sum[fpla_pkg::CNT_W-1:0];
    endfunction

    // Accept only when idle and the result register can take the answer
    assign in_stall = !((state_reg == S_IDLE) && out_room);
    assign accept   = in_valid && !in_stall;
    assign res_load = accept;

    // Decode the command
    assign alloc_ok   = (byte_count == page_size) && (head_reg < fpla_pkg::HEAD_EMPTY);
    assign blk_end    = fpla_pkg::SUM_W'(page_index) + fpla_pkg::SUM_W'(page_count);
    assign blk_oob    = blk_end > fpla_pkg::SUM_FULL;
    assign room       = fpla_pkg::SUM_FULL - fpla_pkg::SUM_W'(pf_reg);
    assign pf_add_one = add_sat(pf_reg, fpla_pkg::CNT_W'(1), room);
    assign pf_add_blk = add_sat(pf_reg, page_count, room);

    // Next state, memory requests and the result item
    always_comb
    begin
        state_next     = state_reg;
        head_next      = head_reg;
        pf_next        = pf_reg;
        alloc_cnt_next = alloc_cnt_reg;
        free_cnt_next  = free_cnt_reg;
        cursor_next    = cursor_reg;
        remain_next    = remain_reg;
        tail_next      = tail_reg;

        ram_req.wr_en   = 1'b0;
        ram_req.wr_addr = page_index;
        ram_req.wr_data = head_reg;
        ram_req.rd_en   = 1'b0;
        ram_req.rd_addr = head_reg[fpla_pkg::PAGE_W-1:0];

        res.status       = fpla_pkg::ST_OK;
        res.granted_page = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (command)
                        fpla_pkg::CMD_ALLOC:
                        begin
                            alloc_cnt_next = alloc_cnt_reg + fpla_pkg::STAT_W'(1);
                            if (alloc_ok)
                            begin
                                ram_req.rd_en    = 1'b1;
                                res.granted_page = head_reg[fpla_pkg::PAGE_W-1:0];
                                if (pf_reg != '0)
                                begin
                                    pf_next = pf_reg - fpla_pkg::CNT_W'(1);
                                end
                                state_next = S_POP;
                            end
                            else
                            begin
                                res.status = fpla_pkg::ST_REFUSED;
                            end
                        end
                        fpla_pkg::CMD_FREE:
                        begin
                            free_cnt_next = free_cnt_reg + fpla_pkg::STAT_W'(1);
                            ram_req.wr_en = 1'b1;
                            head_next     = fpla_pkg::LINK_W'(page_index);
                            pf_next       = pf_add_one;
                        end
                        fpla_pkg::CMD_ADD:
                        begin
                            if (page_count == '0)
                            begin
                                res.status = fpla_pkg::ST_OK;
                            end
                            else if (blk_oob)
                            begin
                                res.status = fpla_pkg::ST_BOUNDS;
                            end
                            else
                            begin
                                tail_next   = head_reg;
                                head_next   = fpla_pkg::LINK_W'(page_index);
                                cursor_next = page_index;
                                remain_next = page_count;
                                pf_next     = pf_add_blk;
                                state_next  = S_FILL;
                            end
                        end
                        default:
                        begin
                            res.status = fpla_pkg::ST_OK;
                        end
                    endcase
                end
            end
            S_POP:
            begin
                // Take the popped page's link as the new head, clamped to empty
                if (ram_rdata > fpla_pkg::HEAD_EMPTY)
                begin
                    head_next = fpla_pkg::HEAD_EMPTY;
                end
                else
                begin
                    head_next = ram_rdata;
                end
                state_next = S_IDLE;
            end
            S_FILL:
            begin
                // Link one page of the block per cycle, the last to the old head
                ram_req.wr_en   = 1'b1;
                ram_req.wr_addr = cursor_reg;
                if (remain_reg == fpla_pkg::CNT_W'(1))
                begin
                    ram_req.wr_data = tail_reg;
                    state_next      = S_IDLE;
                end
                else
                begin
                    ram_req.wr_data = fpla_pkg::LINK_W'(cursor_reg) + fpla_pkg::LINK_W'(1);
                end
                cursor_next = cursor_reg + fpla_pkg::PAGE_W'(1);
                remain_next = remain_reg - fpla_pkg::CNT_W'(1);
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        res.free_pages  = pf_next;
        res.alloc_count = alloc_cnt_next;
        res.free_count  = free_cnt_next;
    end

    // Hold control state and counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= fpla_pkg::HEAD_EMPTY;
            pf_reg        <= '0;
            alloc_cnt_reg <= '0;
            free_cnt_reg  <= '0;
            remain_reg    <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            pf_reg        <= pf_next;
            alloc_cnt_reg <= alloc_cnt_next;
            free_cnt_reg  <= free_cnt_next;
            remain_reg    <= remain_next;
        end
    end

    // Fill cursor and saved tail link
    always_ff @(posedge clk)
    begin
        cursor_reg <= cursor_next;
        tail_reg   <= tail_next;
    end

endmodule
